[rtl/core/pfc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair cipher package
// Shared types, constants and small helpers for the digraph cipher core.
// ----------------------------------------------------------------------------
package pfc_pkg;

    // Square geometry and letter coding
    localparam int SQ_DIM      = 5;
    localparam int SQ_IDX_W    = $clog2(SQ_DIM);
    localparam int LETTER_W    = 5;
    localparam int CFG_WIDE_W  = 60;
    localparam int CFG_IDX_W   = 2;

    localparam logic [LETTER_W-1:0] LETTER_I   = 5'd8;
    localparam logic [LETTER_W-1:0] LETTER_J   = 5'd9;
    localparam logic [LETTER_W-1:0] LETTER_MAX = 5'd25;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MID  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST = 2'd2;

    // Reset contents of the key square
    localparam logic [CFG_WIDE_W-1:0] CELLS_LOW_RST = 60'd445091350149433376;
    localparam logic [CFG_WIDE_W-1:0] CELLS_MID_RST = 60'd891384680460860877;
    localparam logic [LETTER_W-1:0]   CELL_LAST_RST = 5'd25;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef logic [SQ_IDX_W-1:0] t_sq_idx;

    // Key square, element [row][col] holds cell 5*row+col
    typedef logic [SQ_DIM-1:0][SQ_DIM-1:0][LETTER_W-1:0] t_square;

    typedef struct packed {
        logic                mode;
        logic [LETTER_W-1:0] first_letter;
        logic [LETTER_W-1:0] second_letter;
        logic                last_pair;
    } t_pair_in;

    typedef struct packed {
        logic [LETTER_W-1:0] first_out;
        logic [LETTER_W-1:0] second_out;
        logic                pair_error;
        logic                last_out;
    } t_pair_out;

    // Classified digraph handed from front to back
    typedef struct packed {
        logic                mode;
        logic [LETTER_W-1:0] first_letter;
        logic [LETTER_W-1:0] second_letter;
        logic                last_pair;
        logic                pair_error;
        t_sq_idx             row_a;
        t_sq_idx             col_a;
        t_sq_idx             row_b;
        t_sq_idx             col_b;
    } t_job;

    // Step one place forward or back, wrapping within the square
    function automatic t_sq_idx wrap_step(input t_sq_idx x, input logic back);
        t_sq_idx y;
        if (back) begin
            y = (x == '0) ? t_sq_idx'(SQ_DIM - 1) : t_sq_idx'(x - 1'b1);
        end else begin
            y = (x == t_sq_idx'(SQ_DIM - 1)) ? '0 : t_sq_idx'(x + 1'b1);
        end
        return y;
    endfunction

endpackage

[rtl/core/pfc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair cipher front end
// Accepts a digraph, folds j onto i, checks it and locates both letters in
// the key square, then holds the classified job for the queue.
// ----------------------------------------------------------------------------
module pfc_front
    import pfc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_pair_in i_item,
    input  t_square  i_square,
    input  logic     i_queue_full,
    output logic     o_job_valid,
    output t_job     o_job
);

    logic                r_valid;
    logic                n_valid;
    t_job                r_job;
    t_job                n_job;
    logic [LETTER_W-1:0] la;
    logic [LETTER_W-1:0] lb;
    logic                hit_a;
    logic                hit_b;
    t_sq_idx             row_a;
    t_sq_idx             col_a;
    t_sq_idx             row_b;
    t_sq_idx             col_b;
    logic                push;

    // Fold j onto i
    assign la = (i_item.first_letter == LETTER_J) ? LETTER_I : i_item.first_letter;
    assign lb = (i_item.second_letter == LETTER_J) ? LETTER_I : i_item.second_letter;

    // Search the square; scan downwards so the lowest matching cell wins
    always_comb begin
        hit_a = 1'b0;
        hit_b = 1'b0;
        row_a = '0;
        col_a = '0;
        row_b = '0;
        col_b = '0;
        for (int r = SQ_DIM - 1; r >= 0; r--) begin
            for (int c = SQ_DIM - 1; c >= 0; c--) begin
                if (i_square[r][c] == la) begin
                    hit_a = 1'b1;
                    row_a = t_sq_idx'(r);
                    col_a = t_sq_idx'(c);
                end
                if (i_square[r][c] == lb) begin
                    hit_b = 1'b1;
                    row_b = t_sq_idx'(r);
                    col_b = t_sq_idx'(c);
                end
            end
        end
    end

    // Build the job record
    always_comb begin
        n_job.mode          = i_item.mode;
        n_job.first_letter  = i_item.first_letter;
        n_job.second_letter = i_item.second_letter;
        n_job.last_pair     = i_item.last_pair;
        n_job.pair_error    = (la > LETTER_MAX) || (lb > LETTER_MAX) || (la == lb)
                              || !hit_a || !hit_b;
        n_job.row_a         = row_a;
        n_job.col_a         = col_a;
        n_job.row_b         = row_b;
        n_job.col_b         = col_b;
    end

    // Hand the held job on whenever the queue has room
    assign push    = r_valid && !i_queue_full;
    assign n_valid = i_accept || (r_valid && !push);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_job <= n_job;
        end
    end

    assign o_job_valid = push;
    assign o_job       = r_job;

endmodule

[rtl/core/pfc_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair cipher job queue
// Short first-in first-out buffer that decouples the front and back ends.
// ----------------------------------------------------------------------------
module pfc_queue
    import pfc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    // Advance pointers with wrap, track fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_wr_ptr + 1'b1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_rd_ptr + 1'b1);
        end
        if (do_push && !do_pop) begin
            n_count = CNT_W'(r_count + 1'b1);
        end else if (do_pop && !do_push) begin
            n_count = CNT_W'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

`ifndef SYNTHESIS
    // A push into a full queue would lose a job
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue push while full");

    // A pop alone drops the fill level by one
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pop && !do_push) |=> (r_count == CNT_W'($past(r_count) - 1'b1)))
        else $error("queue count did not drop on pop");
`endif

endmodule

[rtl/core/pfc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair cipher back end
// Applies the row, column or rectangle rule to a classified job and
// registers the resulting digraph with a one-cycle strobe.
// ----------------------------------------------------------------------------
module pfc_back
    import pfc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_job_valid,
    input  t_job      i_job,
    input  t_square   i_square,
    output logic      o_result_valid,
    output t_pair_out o_result
);

    logic      r_valid;
    t_pair_out r_result;
    t_pair_out n_result;
    t_sq_idx   tr_a;
    t_sq_idx   tc_a;
    t_sq_idx   tr_b;
    t_sq_idx   tc_b;

    // Pick target cells by rule
    always_comb begin
        if (i_job.row_a == i_job.row_b) begin
            tr_a = i_job.row_a;
            tc_a = wrap_step(i_job.col_a, i_job.mode);
            tr_b = i_job.row_b;
            tc_b = wrap_step(i_job.col_b, i_job.mode);
        end else if (i_job.col_a == i_job.col_b) begin
            tr_a = wrap_step(i_job.row_a, i_job.mode);
            tc_a = i_job.col_a;
            tr_b = wrap_step(i_job.row_b, i_job.mode);
            tc_b = i_job.col_b;
        end else begin
            tr_a = i_job.row_a;
            tc_a = i_job.col_b;
            tr_b = i_job.row_b;
            tc_b = i_job.col_a;
        end
    end

    // Read the square, or pass the letters through on error
    always_comb begin
        n_result.pair_error = i_job.pair_error;
        n_result.last_out   = i_job.last_pair;
        if (i_job.pair_error) begin
            n_result.first_out  = i_job.first_letter;
            n_result.second_out = i_job.second_letter;
        end else begin
            n_result.first_out  = i_square[tr_a][tc_a];
            n_result.second_out = i_square[tr_b][tc_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_job_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_job_valid) begin
            r_result <= n_result;
        end
    end

    assign o_result_valid = r_valid;
    assign o_result       = r_result;

`ifndef SYNTHESIS
    // An error result carries the input letters unchanged
    a_err_passthru: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_job_valid && i_job.pair_error) |=>
            (o_result.first_out == $past(i_job.first_letter)
             && o_result.second_out == $past(i_job.second_letter)))
        else $error("error result does not pass letters through");
`endif

endmodule

[rtl/core/playfair_digraph_cipher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair digraph cipher
// Path: the front end registers an accepted digraph, the queue stores the job
// and the back end registers the result strobe; the result transfers at the edge that ends the strobe cycle.
// Throughput: one digraph per cycle; busy stays low as the back end drains
// the queue every cycle and the receiver cannot stall.
// Reset: synchronous, active low; clears the pipeline and reloads the
// default key square.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher
    import pfc_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_pair_in              i_item,
    output logic                  o_result_valid,
    output t_pair_out             o_result,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_WIDE_W-1:0] i_cfg_data
);

    logic [CFG_WIDE_W-1:0] r_cells_low;
    logic [CFG_WIDE_W-1:0] r_cells_mid;
    logic [LETTER_W-1:0]   r_cell_last;
    t_square               square;
    logic                  accept;
    logic                  front_busy;
    logic                  push;
    t_job                  front_job;
    logic                  queue_full;
    logic                  queue_empty;
    t_job                  head_job;
    logic                  cfg_wr;

    // Configuration writes, always ready
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells_low <= CELLS_LOW_RST;
            r_cells_mid <= CELLS_MID_RST;
            r_cell_last <= CELL_LAST_RST;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_IDX_LOW:  r_cells_low <= i_cfg_data;
                CFG_IDX_MID:  r_cells_mid <= i_cfg_data;
                CFG_IDX_LAST: r_cell_last <= i_cfg_data[LETTER_W-1:0];
                default: ;
            endcase
        end
    end

    // Row-major cells, cell 0 in the low bits
    assign square = {r_cell_last, r_cells_mid, r_cells_low};

    // Hold off a new digraph whenever the queue is full
    assign front_busy = push ? 1'b0 : 1'b0;
    assign busy       = front_busy || queue_full;
    assign accept     = start && !busy;

    pfc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_item       (i_item),
        .i_square     (square),
        .i_queue_full (queue_full),
        .o_job_valid  (push),
        .o_job        (front_job)
    );

    pfc_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (!queue_empty),
        .o_full  (queue_full),
        .o_empty (queue_empty),
        .o_job   (head_job)
    );

    pfc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (!queue_empty),
        .i_job          (head_job),
        .i_square       (square),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

`ifndef SYNTHESIS
    // The back end drains every cycle, so the queue never fills
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("cipher stalled its input");
`endif

endmodule

[tb/playfair_digraph_cipher_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair digraph cipher testbench
// Drives digraphs through the cipher under a series of key squares: a short
// directed run over the row, column and rectangle rules and the error cases,
// then random traffic built mostly from letters of the loaded square. Each
// result is checked field by field against a local model of the cipher.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher_tb;
    import pfc_pkg::*;

    localparam int SQ_CELLS = SQ_DIM * SQ_DIM;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int MAX_REPORTS = 10;
    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;

    typedef logic [LETTER_W-1:0] t_cell_list [SQ_CELLS];

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    t_pair_in              i_item = '0;
    logic                  o_result_valid;
    t_pair_out             o_result;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_IDX_LOW;
    logic [CFG_WIDE_W-1:0] i_cfg_data = '0;

    // Local copy of the key square registers
    logic [CFG_WIDE_W-1:0] key_low = CELLS_LOW_RST;
    logic [CFG_WIDE_W-1:0] key_mid = CELLS_MID_RST;
    logic [LETTER_W-1:0]   key_last = CELL_LAST_RST;

    t_pair_out  cipher_expected[$];
    t_cell_list next_square;
    int         mismatches = 0;
    int         stray_results = 0;
    bit         gaps_on = 1'b1;

    playfair_digraph_cipher i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Bound the run
    initial begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Letter code held in key square cell k
    function automatic logic [LETTER_W-1:0] cell_code(int k);
        if (k < 12) begin
            return key_low[5*k +: 5];
        end else if (k < 24) begin
            return key_mid[5*(k-12) +: 5];
        end
        return key_last;
    endfunction

    // Lowest cell holding the letter, SQ_CELLS if none
    function automatic int locate_letter(logic [LETTER_W-1:0] letter);
        for (int k = 0; k < SQ_CELLS; k++) begin
            if (cell_code(k) == letter) begin
                return k;
            end
        end
        return SQ_CELLS;
    endfunction

    function automatic logic [LETTER_W-1:0] cell_at_rc(int r, int c);
        return cell_code((r % SQ_DIM) * SQ_DIM + (c % SQ_DIM));
    endfunction

    // Apply the Playfair rules to one digraph under the current square
    function automatic t_pair_out encipher_digraph(t_pair_in p);
        logic [LETTER_W-1:0] la, lb;
        int        ka, kb, ra, ca, rb, cb, shift;
        t_pair_out r;
        r.first_out  = p.first_letter;
        r.second_out = p.second_letter;
        r.pair_error = 1'b0;
        r.last_out   = p.last_pair;
        la = (p.first_letter == LETTER_J) ? LETTER_I : p.first_letter;
        lb = (p.second_letter == LETTER_J) ? LETTER_I : p.second_letter;
        if (la > LETTER_MAX || lb > LETTER_MAX || la == lb) begin
            r.pair_error = 1'b1;
            return r;
        end
        ka = locate_letter(la);
        kb = locate_letter(lb);
        if (ka >= SQ_CELLS || kb >= SQ_CELLS) begin
            r.pair_error = 1'b1;
            return r;
        end
        ra = ka / SQ_DIM;
        ca = ka % SQ_DIM;
        rb = kb / SQ_DIM;
        cb = kb % SQ_DIM;
        shift = (p.mode == MODE_DECRYPT) ? SQ_DIM - 1 : 1;
        if (ra == rb) begin
            r.first_out  = cell_at_rc(ra, ca + shift);
            r.second_out = cell_at_rc(rb, cb + shift);
        end else if (ca == cb) begin
            r.first_out  = cell_at_rc(ra + shift, ca);
            r.second_out = cell_at_rc(rb + shift, cb);
        end else begin
            r.first_out  = cell_at_rc(ra, cb);
            r.second_out = cell_at_rc(rb, ca);
        end
        return r;
    endfunction

    // Track configuration writes, predict each digraph transfer, check results
    always @(posedge i_clk) begin : track_and_check
        t_pair_out want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_IDX_LOW:  key_low <= i_cfg_data;
                    CFG_IDX_MID:  key_mid <= i_cfg_data;
                    CFG_IDX_LAST: key_last <= i_cfg_data[LETTER_W-1:0];
                    default: ;
                endcase
            end
            if (start && !busy) begin
                cipher_expected.push_back(encipher_digraph(i_item));
            end
            if (o_result_valid) begin
                if (cipher_expected.size() == 0) begin
                    stray_results++;
                    $display("%0t: result with none expected: %p", $realtime, o_result);
                end else begin
                    want = cipher_expected.pop_front();
                    if (o_result.first_out !== want.first_out
                            || o_result.second_out !== want.second_out
                            || o_result.pair_error !== want.pair_error
                            || o_result.last_out !== want.last_out) begin
                        if (mismatches < MAX_REPORTS) begin
                            $display("%0t: mismatch expected %p got %p",
                                     $realtime, want, o_result);
                        end
                        mismatches++;
                    end
                end
            end
        end
    end

    function automatic int draw_gap();
        return gaps_on ? int'($urandom_range(0, 17)) : 0;
    endfunction

    function automatic t_pair_in make_pair(logic mode, logic [LETTER_W-1:0] a,
                                           logic [LETTER_W-1:0] b, logic last_pair);
        t_pair_in p;
        p.mode          = mode;
        p.first_letter  = a;
        p.second_letter = b;
        p.last_pair     = last_pair;
        return p;
    endfunction

    // Offer one digraph and hold it until the transfer
    task automatic send_pair(t_pair_in p);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= p;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Drop start and wait until every expected result has come back
    task automatic drain_pipeline();
        start <= 1'b0;
        @(posedge i_clk);
        while (cipher_expected.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_WIDE_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Pack next_square into the three registers and write them
    task automatic load_square();
        logic [CFG_WIDE_W-1:0] low, mid;
        low = '0;
        mid = '0;
        for (int k = 0; k < 12; k++) begin
            low[5*k +: 5] = next_square[k];
            mid[5*k +: 5] = next_square[k+12];
        end
        write_reg(CFG_IDX_LOW, low);
        write_reg(CFG_IDX_MID, mid);
        write_reg(CFG_IDX_LAST, CFG_WIDE_W'(next_square[24]));
    endtask

    // Shuffled keyed square without j; optionally store j where i belongs
    task automatic build_keyed_square(bit j_for_i);
        int                  pick;
        logic [LETTER_W-1:0] swap;
        for (int k = 0; k < SQ_CELLS; k++) begin
            next_square[k] = (k < 9) ? LETTER_W'(k) : LETTER_W'(k + 1);
        end
        for (int k = SQ_CELLS - 1; k > 0; k--) begin
            pick = $urandom_range(0, k);
            swap = next_square[k];
            next_square[k] = next_square[pick];
            next_square[pick] = swap;
        end
        if (j_for_i) begin
            for (int k = 0; k < SQ_CELLS; k++) begin
                if (next_square[k] == LETTER_I) begin
                    next_square[k] = LETTER_J;
                end
            end
        end
    endtask

    // Mostly digraphs drawn from the square in each rule, some raw noise
    function automatic t_pair_in random_pair();
        int                  kind, ka, kb;
        logic [LETTER_W-1:0] a, b;
        kind = $urandom_range(0, 9);
        ka = $urandom_range(0, SQ_CELLS - 1);
        case (kind)
            0: begin
                a = LETTER_W'($urandom);
                b = LETTER_W'($urandom);
            end
            1: begin
                a = LETTER_W'($urandom_range(0, 25));
                b = LETTER_W'($urandom_range(0, 25));
            end
            default: begin
                if (kind % 3 == 0) begin
                    kb = (ka / SQ_DIM) * SQ_DIM
                         + (ka % SQ_DIM + 1 + $urandom_range(0, 3)) % SQ_DIM;
                end else if (kind % 3 == 1) begin
                    kb = (ka + SQ_DIM * (1 + $urandom_range(0, 3))) % SQ_CELLS;
                end else begin
                    kb = $urandom_range(0, SQ_CELLS - 1);
                end
                a = cell_code(ka);
                b = cell_code(kb);
                if (a == LETTER_I && $urandom_range(0, 1)) a = LETTER_J;
                if (b == LETTER_I && $urandom_range(0, 1)) b = LETTER_J;
            end
        endcase
        return make_pair(logic'($urandom_range(0, 1)), a, b,
                         logic'($urandom_range(0, 1)));
    endfunction

    task automatic test_reset_square();
        send_pair(make_pair(MODE_ENCRYPT, 5'd0, 5'd25, 1'b0));
        send_pair(make_pair(MODE_DECRYPT, 5'd2, 5'd19, 1'b1));
        drain_pipeline();
    endtask

    // Plain alphabet square: rows abcde, fghik, lmnop, qrstu, vwxyz
    task automatic test_cipher_rules();
        for (int k = 0; k < SQ_CELLS; k++) begin
            next_square[k] = (k < 9) ? LETTER_W'(k) : LETTER_W'(k + 1);
        end
        load_square();
        // same row, wrapping both ways
        send_pair(make_pair(MODE_ENCRYPT, 5'd0, 5'd4, 1'b0));
        send_pair(make_pair(MODE_DECRYPT, 5'd0, 5'd4, 1'b0));
        // same column, wrapping both ways
        send_pair(make_pair(MODE_ENCRYPT, 5'd0, 5'd21, 1'b0));
        send_pair(make_pair(MODE_DECRYPT, 5'd21, 5'd0, 1'b1));
        // rectangle across the corners
        send_pair(make_pair(MODE_ENCRYPT, 5'd0, 5'd25, 1'b1));
        send_pair(make_pair(MODE_DECRYPT, 5'd25, 5'd0, 1'b0));
        // j read as i
        send_pair(make_pair(MODE_ENCRYPT, LETTER_J, 5'd0, 1'b0));
        // i with j, and plain equal letters
        send_pair(make_pair(MODE_ENCRYPT, LETTER_I, LETTER_J, 1'b0));
        send_pair(make_pair(MODE_DECRYPT, 5'd3, 5'd3, 1'b0));
        // codes above the alphabet
        send_pair(make_pair(MODE_ENCRYPT, 5'd31, 5'd0, 1'b1));
        send_pair(make_pair(MODE_DECRYPT, 5'd25, 5'd26, 1'b0));
        drain_pipeline();
    endtask

    // Square with j stored, a code above z and duplicated letters
    task automatic test_odd_square();
        next_square[0] = LETTER_J;
        next_square[1] = 5'd31;
        for (int k = 2; k < SQ_CELLS; k++) begin
            next_square[k] = LETTER_W'((k - 2) % 13);
        end
        load_square();
        send_pair(make_pair(MODE_ENCRYPT, 5'd0, 5'd1, 1'b0));
        send_pair(make_pair(MODE_ENCRYPT, 5'd0, 5'd5, 1'b0));
        send_pair(make_pair(MODE_DECRYPT, 5'd4, 5'd0, 1'b1));
        send_pair(make_pair(MODE_ENCRYPT, 5'd20, 5'd1, 1'b0));
        send_pair(make_pair(MODE_DECRYPT, LETTER_J, 5'd0, 1'b0));
        drain_pipeline();
    endtask

    // All-zero register contents, then all-ones low and middle registers with z in the last cell
    task automatic test_config_extremes();
        write_reg(CFG_IDX_LOW, '0);
        write_reg(CFG_IDX_MID, '0);
        write_reg(CFG_IDX_LAST, '0);
        send_pair(make_pair(MODE_ENCRYPT, 5'd0, 5'd1, 1'b0));
        send_pair(make_pair(MODE_DECRYPT, LETTER_J, LETTER_I, 1'b1));
        drain_pipeline();
        write_reg(CFG_IDX_LOW, '1);
        write_reg(CFG_IDX_MID, '1);
        write_reg(CFG_IDX_LAST, CFG_WIDE_W'(LETTER_MAX));
        send_pair(make_pair(MODE_ENCRYPT, 5'd25, 5'd0, 1'b0));
        send_pair(make_pair(MODE_DECRYPT, 5'd24, 5'd25, 1'b1));
        drain_pipeline();
    endtask

    task automatic test_random_traffic();
        for (int ph = 0; ph < PHASES; ph++) begin
            gaps_on = (ph % 3 != 1);
            if (ph % 4 == 3) begin
                write_reg(CFG_IDX_LOW, CFG_WIDE_W'({$urandom, $urandom}));
                write_reg(CFG_IDX_MID, CFG_WIDE_W'({$urandom, $urandom}));
                write_reg(CFG_IDX_LAST, CFG_WIDE_W'($urandom_range(0, 31)));
            end else begin
                build_keyed_square(ph % 4 == 2);
                load_square();
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_pair(random_pair());
            end
            drain_pipeline();
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_square();
        test_cipher_rules();
        test_odd_square();
        test_config_extremes();
        test_random_traffic();
        drain_pipeline();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && stray_results == 0 && cipher_expected.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
